// ===== rtl/bpfs_pkg.sv =====
// bpfs_pkg: shared constants, types and table builders for the Blinn-Phong shader.
// Used by bpfs_norm, bpfs_pow and blinn_phong_fragment_shader. No dependencies.
package bpfs_pkg;

   localparam int COMP_W          = 16;   // raw component width, COMP_W-4 fraction bits
   localparam int POW_TABLE_DEPTH = 256;  // log2/exp2 table intervals
   localparam int CFG_W           = 48;
   localparam int SHINE_W         = 16;
   localparam int CSR_IDX_W       = 3;

   localparam logic [CSR_IDX_W-1:0] REG_AMBIENT_COLOR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LIGHT_COLOR     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LIGHT_DIRECTION = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_AMBIENT_COEFF   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DIFFUSE_COEFF   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SPECULAR_COEFF  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SHININESS       = 3'd6;

   // pipeline geometry
   localparam int SQ_STAGES  = 16;  // two root bits per stage
   localparam int DV_STAGES  = 8;   // two quotient bits per stage
   localparam int NORM_LAT   = 4 + SQ_STAGES + 1 + DV_STAGES + 1;
   localparam int POW_LAT    = 5;
   localparam int PIPE_DEPTH = 2 * NORM_LAT + 10;

   localparam int IDX_W = $clog2(POW_TABLE_DEPTH + 1);

   localparam int Q12_UP = (COMP_W < 16) ? 16 - COMP_W : 0;
   localparam int Q12_DN = (COMP_W > 16) ? COMP_W - 16 : 1;

   typedef logic signed [15:0] q12_type;
   typedef q12_type [2:0] vec_type;
   typedef logic [16:0] tab_type [POW_TABLE_DEPTH+1];

   function automatic logic [63:0] isqrt_c(input logic [63:0] n);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] b;
      v   = n;
      res = 64'd0;
      b   = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 64'd0) begin
         if (v >= res + b) begin
            v   = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // LOG[i] = log2(1 + i/D) in Q.16, squaring method
   function automatic tab_type log_table();
      tab_type     t;
      logic [63:0] m;
      logic [63:0] r;
      for (int i = 0; i <= POW_TABLE_DEPTH; i++) begin
         m = ((64'(POW_TABLE_DEPTH) + 64'(i)) << 30) / POW_TABLE_DEPTH;
         r = 64'd0;
         if (m >= (64'd1 << 31)) begin
            r = 64'd131072;
         end else begin
            for (int k = 1; k <= 17; k++) begin
               m = (m * m) >> 30;
               r = r << 1;
               if (m >= (64'd1 << 31)) begin
                  r = r | 64'd1;
                  m = m >> 1;
               end
            end
         end
         t[i] = 17'((r + 64'd1) >> 1);
      end
      return t;
   endfunction

   // EXP[j] = 2^(-j/D) in Q.16
   function automatic tab_type exp_table();
      tab_type     t;
      logic [63:0] c [31];
      logic [63:0] f;
      logic [63:0] acc;
      c[0] = 64'd0;
      c[1] = isqrt_c(64'd1 << 59);
      for (int k = 2; k <= 30; k++) c[k] = isqrt_c(c[k-1] << 30);
      for (int i = 0; i <= POW_TABLE_DEPTH; i++) begin
         f   = (64'(i) << 30) / POW_TABLE_DEPTH;
         acc = 64'd1 << 30;
         if (f >= (64'd1 << 30)) begin
            acc = 64'd1 << 29;
            f   = f - (64'd1 << 30);
         end
         for (int k = 1; k <= 30; k++) begin
            if (((f >> (30 - k)) & 64'd1) != 64'd0)
               acc = (acc * c[k] + (64'd1 << 29)) >> 30;
         end
         t[i] = 17'((acc + (64'd1 << 13)) >> 14);
      end
      return t;
   endfunction

   localparam tab_type LOG_TAB = log_table();
   localparam tab_type EXP_TAB = exp_table();

   // raw component -> signed Q3.12
   function automatic q12_type to_q12(input logic [COMP_W-1:0] raw);
      logic signed [47:0] v;
      logic signed [47:0] r;
      v = 48'(signed'(raw));
      if (COMP_W <= 16) begin
         r = v <<< Q12_UP;
      end else begin
         r = (v + (48'sd1 <<< (Q12_DN - 1))) >>> Q12_DN;
         if (r > 48'sd32767) r = 48'sd32767;
      end
      return q12_type'(r[15:0]);
   endfunction

   function automatic q12_type comp(input logic [CFG_W-1:0] regv, input int k);
      logic [63:0] t;
      t = 64'(regv) >> (k * COMP_W);
      return to_q12(t[COMP_W-1:0]);
   endfunction

endpackage

// ===== rtl/bpfs_norm.sv =====
// bpfs_norm: pipelined 3-vector normalizer, Q3.12 in, Q1.14 out.
// Depends on bpfs_pkg (vec_type, SQ_STAGES, DV_STAGES, NORM_LAT).
module bpfs_norm (
   input  logic              clock,
   input  bpfs_pkg::vec_type vec_in,
   output bpfs_pkg::vec_type vec_out
);

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] res;
   } sq_type;

   typedef struct packed {
      logic [47:0] num;
      logic [15:0] quo;
   } dv_type;

   typedef struct packed {
      logic [2:0][30:0] a;
      logic [2:0]       neg;
      logic             zero;
   } side_type;

   function automatic sq_type sqrt_step(input sq_type s, input int i);
      logic [63:0] b;
      sq_type      o;
      b = 64'd1 << (2 * i);
      o = s;
      if (s.rem >= s.res + b) begin
         o.rem = s.rem - (s.res + b);
         o.res = (s.res >> 1) + b;
      end else begin
         o.res = s.res >> 1;
      end
      return o;
   endfunction

   function automatic dv_type div_step(input dv_type s, input logic [31:0] r, input int j);
      logic [47:0] d;
      dv_type      o;
      d = 48'(r) << j;
      o = s;
      if (s.num >= d) begin
         o.num    = s.num - d;
         o.quo[j] = 1'b1;
      end
      return o;
   endfunction

   // stage 1: magnitudes and scale
   logic [15:0] abs_c [3];
   logic [15:0] max_c;
   logic [4:0]  msb_c;

   always_comb begin
      max_c = 16'd0;
      msb_c = 5'd0;
      for (int i = 0; i < 3; i++) begin
         abs_c[i] = vec_in[i][15] ? 16'(-vec_in[i]) : 16'(vec_in[i]);
         if (abs_c[i] > max_c) max_c = abs_c[i];
      end
      for (int b = 0; b < 16; b++) begin
         if (max_c[b]) msb_c = 5'(b);
      end
   end

   logic [15:0] n1_abs_ff [3];
   logic [2:0]  n1_neg_ff;
   logic [4:0]  n1_k_ff;
   logic        n1_zero_ff;

   always_ff @(posedge clock) begin
      n1_abs_ff  <= abs_c;
      n1_neg_ff  <= {vec_in[2][15], vec_in[1][15], vec_in[0][15]};
      n1_k_ff    <= 5'd30 - msb_c;
      n1_zero_ff <= (max_c == 16'd0);
   end

   // stage 2: scale so the largest magnitude reaches 2^30
   side_type n2_ff;
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) n2_ff.a[i] <= 31'(n1_abs_ff[i]) << n1_k_ff;
      n2_ff.neg  <= n1_neg_ff;
      n2_ff.zero <= n1_zero_ff;
   end

   // stage 3: squares
   logic [61:0] n3_sq_ff [3];
   side_type    n3_ff;
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) n3_sq_ff[i] <= {31'd0, n2_ff.a[i]} * {31'd0, n2_ff.a[i]};
      n3_ff <= n2_ff;
   end

   // stage 4: sum of squares
   logic [63:0] n4_sum_ff;
   side_type    n4_ff;
   always_ff @(posedge clock) begin
      n4_sum_ff <= 64'(n3_sq_ff[0]) + 64'(n3_sq_ff[1]) + 64'(n3_sq_ff[2]);
      n4_ff     <= n3_ff;
   end

   // integer square root, two bits a stage
   sq_type   sq_ff  [bpfs_pkg::SQ_STAGES];
   side_type sqs_ff [bpfs_pkg::SQ_STAGES];

   for (genvar s = 0; s < bpfs_pkg::SQ_STAGES; s++) begin : g_sqrt
      sq_type   sq_in;
      side_type side_in;
      if (s == 0) begin : g_first
         assign sq_in   = '{rem: n4_sum_ff, res: 64'd0};
         assign side_in = n4_ff;
      end else begin : g_next
         assign sq_in   = sq_ff[s-1];
         assign side_in = sqs_ff[s-1];
      end
      always_ff @(posedge clock) begin
         sq_ff[s]  <= sqrt_step(sqrt_step(sq_in, 31 - 2 * s), 30 - 2 * s);
         sqs_ff[s] <= side_in;
      end
   end

   // divide setup: numerator a*2^14 + r/2
   dv_type      d0_ff [3];
   logic [31:0] d0_r_ff;
   side_type    d0s_ff;
   logic [31:0] root_c;

   assign root_c = sq_ff[bpfs_pkg::SQ_STAGES-1].res[31:0];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         d0_ff[i].num <= (48'(sqs_ff[bpfs_pkg::SQ_STAGES-1].a[i]) << 14) + 48'(root_c >> 1);
         d0_ff[i].quo <= 16'd0;
      end
      d0_r_ff <= root_c;
      d0s_ff  <= sqs_ff[bpfs_pkg::SQ_STAGES-1];
   end

   // restoring divide, two quotient bits a stage
   dv_type      dv_ff  [bpfs_pkg::DV_STAGES][3];
   logic [31:0] dvr_ff [bpfs_pkg::DV_STAGES];
   side_type    dvs_ff [bpfs_pkg::DV_STAGES];

   for (genvar s = 0; s < bpfs_pkg::DV_STAGES; s++) begin : g_div
      dv_type      dv_in [3];
      logic [31:0] r_in;
      side_type    side_in;
      if (s == 0) begin : g_first
         assign dv_in   = d0_ff;
         assign r_in    = d0_r_ff;
         assign side_in = d0s_ff;
      end else begin : g_next
         assign dv_in   = dv_ff[s-1];
         assign r_in    = dvr_ff[s-1];
         assign side_in = dvs_ff[s-1];
      end
      always_ff @(posedge clock) begin
         for (int i = 0; i < 3; i++)
            dv_ff[s][i] <= div_step(div_step(dv_in[i], r_in, 15 - 2 * s), r_in, 14 - 2 * s);
         dvr_ff[s] <= r_in;
         dvs_ff[s] <= side_in;
      end
   end

   // sign restore
   bpfs_pkg::vec_type out_ff;
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (dvs_ff[bpfs_pkg::DV_STAGES-1].zero) begin
            out_ff[i] <= 16'sd0;
         end else if (dvs_ff[bpfs_pkg::DV_STAGES-1].neg[i]) begin
            out_ff[i] <= -$signed({1'b0, dv_ff[bpfs_pkg::DV_STAGES-1][i].quo[14:0]});
         end else begin
            out_ff[i] <= $signed({1'b0, dv_ff[bpfs_pkg::DV_STAGES-1][i].quo[14:0]});
         end
      end
   end

   assign vec_out = out_ff;

   // a zero vector comes out as zero, not as a divide-by-zero pattern
   a_zero_vec : assert property (@(posedge clock)
      vec_in == '0 |-> ##(bpfs_pkg::NORM_LAT) vec_out == '0)
      else $error("bpfs_norm: zero vector did not normalize to zero");

endmodule

// ===== rtl/bpfs_pow.sv =====
// bpfs_pow: pipelined x^shininess via exp2(shininess * log2 x) table lookups.
// Depends on bpfs_pkg (LOG_TAB, EXP_TAB, POW_TABLE_DEPTH, POW_LAT).
module bpfs_pow (
   input  logic                           clock,
   input  logic [14:0]                    x_in,
   input  logic [bpfs_pkg::SHINE_W-1:0]   shininess,
   output logic [14:0]                    spec_out
);

   localparam int D = bpfs_pkg::POW_TABLE_DEPTH;
   localparam int IW = bpfs_pkg::IDX_W;

   // stage 1: leading one, mantissa fraction, log index
   logic [3:0]  p_c;
   logic [3:0]  sh_c;
   logic [14:0] nrm_c;
   logic [31:0] idx1_c;

   always_comb begin
      p_c = 4'd0;
      for (int b = 0; b < 15; b++) begin
         if (x_in[b]) p_c = 4'(b);
      end
      sh_c   = 4'd14 - p_c;
      nrm_c  = x_in << sh_c;
      idx1_c = (32'(nrm_c[13:0]) * 32'(D) + 32'd8192) >> 14;
      if (idx1_c > 32'(D)) idx1_c = 32'(D);
   end

   logic [IW-1:0] p1_idx_ff;
   logic [3:0]    p1_sh_ff;
   logic          p1_zero_ff;

   always_ff @(posedge clock) begin
      p1_idx_ff  <= idx1_c[IW-1:0];
      p1_sh_ff   <= sh_c;
      p1_zero_ff <= (x_in == 15'd0);
   end

   // stage 2: -log2 x in Q.16
   logic [19:0] p2_elog_ff;
   logic        p2_zero_ff;

   always_ff @(posedge clock) begin
      p2_elog_ff <= {p1_sh_ff, 16'd0} - 20'(bpfs_pkg::LOG_TAB[p1_idx_ff]);
      p2_zero_ff <= p1_zero_ff;
   end

   // stage 3: scale by exponent
   logic [35:0] p3_prod_ff;
   logic        p3_zero_ff;

   always_ff @(posedge clock) begin
      p3_prod_ff <= {20'd0, shininess} * {16'd0, p2_elog_ff};
      p3_zero_ff <= p2_zero_ff;
   end

   // stage 4: split into shift and exp index
   logic [35:0] er_c;
   logic [27:0] e_c;
   logic [31:0] idx2_c;

   always_comb begin
      er_c   = p3_prod_ff + 36'd128;
      e_c    = er_c[35:8];
      idx2_c = (32'(e_c[15:0]) * 32'(D) + 32'd32768) >> 16;
      if (idx2_c > 32'(D)) idx2_c = 32'(D);
   end

   logic [IW-1:0] p4_idx_ff;
   logic [4:0]    p4_q_ff;
   logic          p4_zero_ff;

   always_ff @(posedge clock) begin
      p4_idx_ff  <= idx2_c[IW-1:0];
      p4_q_ff    <= e_c[20:16];
      p4_zero_ff <= p3_zero_ff || (e_c[27:16] > 12'd16);
   end

   // stage 5: exp lookup, shift, round to Q1.14
   logic [16:0] val_c;
   logic [17:0] rnd_c;
   logic [14:0] spec_ff;

   always_comb begin
      val_c = bpfs_pkg::EXP_TAB[p4_idx_ff] >> p4_q_ff;
      rnd_c = (18'(val_c) + 18'd2) >> 2;
   end

   always_ff @(posedge clock) begin
      spec_ff <= p4_zero_ff ? 15'd0 : rnd_c[14:0];
   end

   assign spec_out = spec_ff;

   a_pow_zero : assert property (@(posedge clock)
      x_in == 15'd0 |-> ##(bpfs_pkg::POW_LAT) spec_out == 15'd0)
      else $error("bpfs_pow: zero base gave nonzero power");

endmodule

// ===== rtl/blinn_phong_fragment_shader.sv =====
// blinn_phong_fragment_shader: top level, one directional light Blinn-Phong shading.
// Depends on bpfs_pkg, bpfs_norm, bpfs_pow.
//
//   channel  ports                               direction  handshake
//   request  start, busy, req_normal_{x,y,z}     in         start && !busy
//   result   rsp_strobe, rsp_{red,green,blue}    out        strobe, one cycle
//   csr      csr_we, csr_index, csr_wdata        in         write on csr_we
//
// A new request is taken every clock; busy is always low.
// The strobe is raised together with the result on rsp_{red,green,blue}; the path
// runs through the normalizer, the wait for the half vector, the dot products,
// the power stage and the color stage.
// reset clears the csr registers and the valid pipe; data regs are not reset.
// The receiver cannot stall, so the pipe never stops.
module blinn_phong_fragment_shader (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [bpfs_pkg::COMP_W-1:0] req_normal_x,
   input  logic signed [bpfs_pkg::COMP_W-1:0] req_normal_y,
   input  logic signed [bpfs_pkg::COMP_W-1:0] req_normal_z,
   output logic                            rsp_strobe,
   output logic [15:0]                     rsp_red,
   output logic [15:0]                     rsp_green,
   output logic [15:0]                     rsp_blue,
   input  logic                            csr_we,
   input  logic [bpfs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpfs_pkg::CFG_W-1:0]      csr_wdata
);

   localparam int NL = bpfs_pkg::NORM_LAT;
   localparam int PL = bpfs_pkg::POW_LAT;
   localparam int PD = bpfs_pkg::PIPE_DEPTH;

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // ---------------- csr registers ----------------
   logic [bpfs_pkg::CFG_W-1:0]   amb_color_ff;
   logic [bpfs_pkg::CFG_W-1:0]   light_color_ff;
   logic [bpfs_pkg::CFG_W-1:0]   light_dir_ff;
   logic [bpfs_pkg::CFG_W-1:0]   amb_coeff_ff;
   logic [bpfs_pkg::CFG_W-1:0]   diff_coeff_ff;
   logic [bpfs_pkg::CFG_W-1:0]   spec_coeff_ff;
   logic [bpfs_pkg::SHINE_W-1:0] shininess_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         amb_color_ff   <= '0;
         light_color_ff <= '0;
         light_dir_ff   <= '0;
         amb_coeff_ff   <= '0;
         diff_coeff_ff  <= '0;
         spec_coeff_ff  <= '0;
         shininess_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            bpfs_pkg::REG_AMBIENT_COLOR:   amb_color_ff   <= csr_wdata;
            bpfs_pkg::REG_LIGHT_COLOR:     light_color_ff <= csr_wdata;
            bpfs_pkg::REG_LIGHT_DIRECTION: light_dir_ff   <= csr_wdata;
            bpfs_pkg::REG_AMBIENT_COEFF:   amb_coeff_ff   <= csr_wdata;
            bpfs_pkg::REG_DIFFUSE_COEFF:   diff_coeff_ff  <= csr_wdata;
            bpfs_pkg::REG_SPECULAR_COEFF:  spec_coeff_ff  <= csr_wdata;
            bpfs_pkg::REG_SHININESS:       shininess_ff   <= csr_wdata[bpfs_pkg::SHINE_W-1:0];
            default: ;  // unmapped index, dropped
         endcase
      end
   end

   // ---------------- valid pipe ----------------
   // vld_ff[0] is set at the accept edge; each higher bit is a registered copy of the bit below
   logic [PD-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= {vld_ff[PD-2:0], accept};
   end

   // ---------------- normalizers ----------------
   // Light and half vectors run free off the csr value. The half vector seen
   // by a request reflects the csr contents of the cycle after its accept,
   // which is why the normal is held in the n_dly_ff delay line.
   bpfs_pkg::vec_type n_in;
   bpfs_pkg::vec_type n_unit;
   bpfs_pkg::vec_type l_in;
   bpfs_pkg::vec_type l_unit;
   bpfs_pkg::vec_type h_in;
   bpfs_pkg::vec_type h_unit;
   logic signed [16:0] hz_c;

   always_comb begin
      n_in[0] = bpfs_pkg::to_q12(req_normal_x);
      n_in[1] = bpfs_pkg::to_q12(req_normal_y);
      n_in[2] = bpfs_pkg::to_q12(req_normal_z);
      for (int k = 0; k < 3; k++) l_in[k] = bpfs_pkg::comp(light_dir_ff, k);
      // half vector = l + view, view is (0,0,-1)
      hz_c    = 17'(l_unit[2]) - 17'sd16384;
      h_in[0] = l_unit[0];
      h_in[1] = l_unit[1];
      h_in[2] = bpfs_pkg::q12_type'(hz_c[15:0]);
   end

   bpfs_norm u_norm_n (.clock(clock), .vec_in(n_in), .vec_out(n_unit));
   bpfs_norm u_norm_l (.clock(clock), .vec_in(l_in), .vec_out(l_unit));
   bpfs_norm u_norm_h (.clock(clock), .vec_in(h_in), .vec_out(h_unit));

   bpfs_pkg::vec_type n_dly_ff [NL+1];
   always_ff @(posedge clock) begin
      n_dly_ff[0] <= n_unit;
      for (int j = 1; j <= NL; j++) n_dly_ff[j] <= n_dly_ff[j-1];
   end

   // ---------------- dot products ----------------
   function automatic logic [14:0] dot_clamp(input logic signed [31:0] a,
                                             input logic signed [31:0] b,
                                             input logic signed [31:0] c);
      logic signed [33:0] s;
      logic signed [33:0] r;
      s = 34'(a) + 34'(b) + 34'(c);
      r = (s + 34'sd8192) >>> 14;
      if (s <= 34'sd0)           return 15'd0;
      else if (r > 34'sd16384)   return 15'd16384;
      else                       return r[14:0];
   endfunction

   logic signed [31:0] nl_prod_ff [3];
   logic signed [31:0] nh_prod_ff [3];

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         nl_prod_ff[k] <= n_dly_ff[NL][k] * l_unit[k];
         nh_prod_ff[k] <= n_dly_ff[NL][k] * h_unit[k];
      end
   end

   logic [14:0] lamb_ff;
   logic [14:0] ndoth_ff;

   always_ff @(posedge clock) begin
      lamb_ff  <= dot_clamp(nl_prod_ff[0], nl_prod_ff[1], nl_prod_ff[2]);
      ndoth_ff <= dot_clamp(nh_prod_ff[0], nh_prod_ff[1], nh_prod_ff[2]);
   end

   // ---------------- specular power ----------------
   logic [14:0] spec;
   bpfs_pow u_pow (.clock(clock), .x_in(ndoth_ff), .shininess(shininess_ff), .spec_out(spec));

   logic [14:0] lamb_dly_ff [PL];
   always_ff @(posedge clock) begin
      lamb_dly_ff[0] <= lamb_ff;
      for (int j = 1; j < PL; j++) lamb_dly_ff[j] <= lamb_dly_ff[j-1];
   end

   // ---------------- color ----------------
   // csr-only products, refreshed every cycle
   logic signed [31:0] amb_ff  [3];
   logic signed [31:0] kdlc_ff [3];

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         amb_ff[k]  <= bpfs_pkg::comp(amb_color_ff, k) * bpfs_pkg::comp(amb_coeff_ff, k);
         kdlc_ff[k] <= bpfs_pkg::comp(diff_coeff_ff, k) * bpfs_pkg::comp(light_color_ff, k);
      end
   end

   logic signed [47:0] dif_ff [3];
   logic signed [31:0] spc_ff [3];

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         dif_ff[k] <= kdlc_ff[k] * $signed({1'b0, lamb_dly_ff[PL-1]});
         spc_ff[k] <= $signed({1'b0, spec}) * bpfs_pkg::comp(spec_coeff_ff, k);
      end
   end

   // sum in Q.38, round to Q4.12, saturate
   logic signed [47:0] acc_c [3];
   logic [47:0]        rnd_c [3];
   logic [15:0]        chan_c [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         acc_c[k] = (48'(amb_ff[k]) <<< 14) + dif_ff[k] + (48'(spc_ff[k]) <<< 12);
         rnd_c[k] = (48'(acc_c[k]) + 48'd33554432) >> 26;
         if (acc_c[k] <= 48'sd0)          chan_c[k] = 16'd0;
         else if (rnd_c[k] > 48'd65535)   chan_c[k] = 16'hFFFF;
         else                             chan_c[k] = rnd_c[k][15:0];
      end
   end

   logic [15:0] out_ff [3];
   always_ff @(posedge clock) begin
      out_ff <= chan_c;
   end

   assign rsp_strobe = vld_ff[PD-1];
   assign rsp_red    = out_ff[0];
   assign rsp_green  = out_ff[1];
   assign rsp_blue   = out_ff[2];

   // every strobe traces back to exactly one accepted request
   a_rsp_origin : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, PD))
      else $error("shader: result strobe without a matching request");

endmodule
